// File: rtl/core/rfa_pkg.sv
package rfa_pkg;

   // Widths of the item fields on the channels.
   localparam int DATA_BITS = 32;
   localparam int DEN_BITS  = 31;

   // Default operand width of the block.
   localparam int OPERAND_BITS_DEFAULT = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

endpackage

// File: rtl/core/rfa_if.sv
// Request channel: one item carries an operation and two fractions.
interface rfa_req_if;
   logic                                 valid;
   logic                                 ready;
   rfa_pkg::op_type                      op;
   logic signed [rfa_pkg::DATA_BITS-1:0] left_num;
   logic signed [rfa_pkg::DATA_BITS-1:0] left_den;
   logic signed [rfa_pkg::DATA_BITS-1:0] right_num;
   logic signed [rfa_pkg::DATA_BITS-1:0] right_den;

   modport source (output valid, op, left_num, left_den, right_num, right_den, input ready);
   modport sink   (input valid, op, left_num, left_den, right_num, right_den, output ready);
endinterface

// Response channel: one item carries the reduced fraction and its flags.
interface rfa_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [rfa_pkg::DATA_BITS-1:0] result_num;
   logic        [rfa_pkg::DEN_BITS-1:0]  result_den;
   logic                                 zero_den;
   logic                                 overflow;

   modport source (output valid, result_num, result_den, zero_den, overflow, input ready);
   modport sink   (input valid, result_num, result_den, zero_den, overflow, output ready);
endinterface

// File: rtl/core/rational_fraction_alu.sv
// Rational fraction ALU. Each request item carries an operation (add, subtract, multiply,
// divide) and two signed fractions; the block forms the exact cross-multiplied numerator
// and denominator (W = 2*OPERAND_BITS bits of magnitude), replaces a zero denominator by one
// and raises zero_den, reduces the fraction by its greatest common divisor, puts the sign on
// the numerator and returns one response item. A result that does not fit OPERAND_BITS-bit
// signed numbers comes back as 0/1 with overflow set. Only the low OPERAND_BITS bits of each
// operand count; result_num is sign-extended to 32 bits. The block works on one item at a
// time and is not ready while it does, nor while a finished item waits for the output
// register to free up. The cost is set by the binary GCD loop, which retires at least one
// bit of its two operands per cycle and ends at once for a zero numerator, followed by two
// restoring divisions of W steps each on the shared subtract-and-compare divider. A
// finished item waits in the output register, so the next request is taken while it is
// still pending.
module rational_fraction_alu #(
   parameter int OPERAND_BITS = rfa_pkg::OPERAND_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   rfa_req_if.sink      req_ch,
   rfa_rsp_if.source    rsp_ch
);

   localparam int B     = OPERAND_BITS;
   localparam int W     = 2 * OPERAND_BITS;
   localparam int CNT_W = $clog2(W);

   // 2^(B-1) and 2^(B-1)-1 as W-bit magnitudes, for the range check at the end.
   localparam logic [W-1:0] HALF    = {{(W-1){1'b0}}, 1'b1} << (OPERAND_BITS - 1);
   localparam logic [W-1:0] HALF_M1 = HALF - {{(W-1){1'b0}}, 1'b1};
   localparam logic [W-1:0] ONE_W   = {{(W-1){1'b0}}, 1'b1};
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_D,
      ST_MUL_B,
      ST_COMBINE,
      ST_ZCHECK,
      ST_GCD,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_FINISH
   } state_type;

   // Magnitude of a B-bit two's complement value; the most negative value maps to 2^(B-1).
   function automatic logic [B-1:0] mag_of(input logic [B-1:0] v);
      mag_of = v[B-1] ? (~v + {{(B-1){1'b0}}, 1'b1}) : v;
   endfunction

   state_type       state_ff, state_in;
   rfa_pkg::op_type op_ff, op_in;

   // Operands in sign-magnitude form, captured when an item is accepted.
   logic [B-1:0] ln_mag_ff, ln_mag_in, ld_mag_ff, ld_mag_in;
   logic [B-1:0] rn_mag_ff, rn_mag_in, rd_mag_ff, rd_mag_in;
   logic         ln_neg_ff, ln_neg_in, ld_neg_ff, ld_neg_in;
   logic         rn_neg_ff, rn_neg_in, rd_neg_ff, rd_neg_in;

   // Working registers. num_ff and den_ff hold the raw fraction and later serve as the
   // dividend and quotient shift registers of the two divisions.
   logic [W-1:0]     num_ff, num_in, den_ff, den_in;
   logic [W-1:0]     a_ff, a_in, b_ff, b_in, g_ff, g_in, rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, k_ff, k_in;
   logic             num_neg_ff, num_neg_in, den_neg_ff, den_neg_in;
   logic             sb_neg_ff, sb_neg_in, zden_ff, zden_in;

   // Output register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [rfa_pkg::DATA_BITS-1:0] rnum_ff, rnum_in;
   logic        [rfa_pkg::DEN_BITS-1:0]  rden_ff, rden_in;
   logic                                 rzden_ff, rzden_in, rovf_ff, rovf_in;

   // Shared multiplier.
   logic [B-1:0] mul_x, mul_y;
   logic [W-1:0] mul_p;

   // Divider step.
   logic [W-1:0] dvd;
   logic [W:0]   r_sh, r_diff;
   logic         r_ge;

   // Final check.
   logic                         res_neg, res_ovf;
   logic [rfa_pkg::DATA_BITS-1:0] nm32;

   logic req_take;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.result_num = rnum_ff;
   assign rsp_ch.result_den = rden_ff;
   assign rsp_ch.zero_den   = rzden_ff;
   assign rsp_ch.overflow   = rovf_ff;

   // The multiplier sees the pair that the current step needs: the first numerator
   // product, then the denominator product, then (add and subtract only) the second
   // numerator product.
   always_comb begin
      mul_x = ln_mag_ff;
      mul_y = (op_ff == rfa_pkg::OP_MUL) ? rn_mag_ff : rd_mag_ff;
      case (state_ff)
         ST_MUL_D: begin
            mul_x = ld_mag_ff;
            mul_y = (op_ff == rfa_pkg::OP_DIV) ? rn_mag_ff : rd_mag_ff;
         end
         ST_MUL_B: begin
            mul_x = rn_mag_ff;
            mul_y = ld_mag_ff;
         end
         default: begin
         end
      endcase
   end

   assign mul_p = W'(mul_x) * W'(mul_y);

   // One restoring division step: bring in the next dividend bit and subtract the divisor
   // when it fits. The quotient bit enters the dividend register from the bottom.
   assign dvd    = (state_ff == ST_DIV_NUM) ? num_ff : den_ff;
   assign r_sh   = {rem_ff, dvd[W-1]};
   assign r_diff = r_sh - {1'b0, g_ff};
   assign r_ge   = (r_sh >= {1'b0, g_ff});

   // A zero numerator carries no sign.
   assign res_neg = (num_ff != '0) && (num_neg_ff != den_neg_ff);
   assign res_ovf = (den_ff > HALF_M1) || (res_neg ? (num_ff > HALF) : (num_ff > HALF_M1));
   assign nm32    = rfa_pkg::DATA_BITS'(num_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ln_mag_in    = ln_mag_ff;
      ld_mag_in    = ld_mag_ff;
      rn_mag_in    = rn_mag_ff;
      rd_mag_in    = rd_mag_ff;
      ln_neg_in    = ln_neg_ff;
      ld_neg_in    = ld_neg_ff;
      rn_neg_in    = rn_neg_ff;
      rd_neg_in    = rd_neg_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      g_in         = g_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      num_neg_in   = num_neg_ff;
      den_neg_in   = den_neg_ff;
      sb_neg_in    = sb_neg_ff;
      zden_in      = zden_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rnum_in      = rnum_ff;
      rden_in      = rden_ff;
      rzden_in     = rzden_ff;
      rovf_in      = rovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in     = req_ch.op;
               ln_neg_in = req_ch.left_num[B-1];
               ld_neg_in = req_ch.left_den[B-1];
               // Subtraction is addition with the second numerator negated.
               rn_neg_in = req_ch.right_num[B-1] ^ (req_ch.op == rfa_pkg::OP_SUB);
               rd_neg_in = req_ch.right_den[B-1];
               ln_mag_in = mag_of(req_ch.left_num[B-1:0]);
               ld_mag_in = mag_of(req_ch.left_den[B-1:0]);
               rn_mag_in = mag_of(req_ch.right_num[B-1:0]);
               rd_mag_in = mag_of(req_ch.right_den[B-1:0]);
               state_in  = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            num_in     = mul_p;
            num_neg_in = ln_neg_ff ^ ((op_ff == rfa_pkg::OP_MUL) ? rn_neg_ff : rd_neg_ff);
            state_in   = ST_MUL_D;
         end
         ST_MUL_D: begin
            den_in     = mul_p;
            den_neg_in = ld_neg_ff ^ ((op_ff == rfa_pkg::OP_DIV) ? rn_neg_ff : rd_neg_ff);
            if (op_ff == rfa_pkg::OP_ADD || op_ff == rfa_pkg::OP_SUB) begin
               state_in = ST_MUL_B;
            end else begin
               state_in = ST_ZCHECK;
            end
         end
         ST_MUL_B: begin
            a_in      = mul_p;
            sb_neg_in = rn_neg_ff ^ ld_neg_ff;
            state_in  = ST_COMBINE;
         end
         ST_COMBINE: begin
            // Signed-magnitude sum of the two cross products.
            if (num_neg_ff == sb_neg_ff) begin
               num_in = num_ff + a_ff;
            end else if (num_ff >= a_ff) begin
               num_in = num_ff - a_ff;
            end else begin
               num_in     = a_ff - num_ff;
               num_neg_in = sb_neg_ff;
            end
            state_in = ST_ZCHECK;
         end
         ST_ZCHECK: begin
            zden_in = (den_ff == '0);
            if (den_ff == '0) begin
               den_in     = ONE_W;
               den_neg_in = 1'b0;
               b_in       = ONE_W;
            end else begin
               b_in = den_ff;
            end
            a_in     = num_ff;
            k_in     = '0;
            state_in = ST_GCD;
         end
         ST_GCD: begin
            // Binary GCD; k_ff counts the common factors of two.
            if (a_ff == '0 || b_ff == '0) begin
               g_in     = (a_ff | b_ff) << k_ff;
               rem_in   = '0;
               cnt_in   = CNT_LAST;
               state_in = ST_DIV_NUM;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = (a_ff - b_ff) >> 1;
            end else begin
               b_in = (b_ff - a_ff) >> 1;
            end
         end
         ST_DIV_NUM: begin
            num_in = {num_ff[W-2:0], r_ge};
            rem_in = r_ge ? r_diff[W-1:0] : r_sh[W-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rem_in   = '0;
               cnt_in   = CNT_LAST;
               state_in = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            den_in = {den_ff[W-2:0], r_ge};
            rem_in = r_ge ? r_diff[W-1:0] : r_sh[W-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Wait here until the output register is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rzden_in     = zden_ff;
               rovf_in      = res_ovf;
               if (res_ovf) begin
                  rnum_in = '0;
                  rden_in = rfa_pkg::DEN_BITS'(1);
               end else begin
                  rnum_in = res_neg ? (rfa_pkg::DATA_BITS'(0) - nm32) : nm32;
                  rden_in = rfa_pkg::DEN_BITS'(den_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      ln_mag_ff  <= ln_mag_in;
      ld_mag_ff  <= ld_mag_in;
      rn_mag_ff  <= rn_mag_in;
      rd_mag_ff  <= rd_mag_in;
      ln_neg_ff  <= ln_neg_in;
      ld_neg_ff  <= ld_neg_in;
      rn_neg_ff  <= rn_neg_in;
      rd_neg_ff  <= rd_neg_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      g_ff       <= g_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      k_ff       <= k_in;
      num_neg_ff <= num_neg_in;
      den_neg_ff <= den_neg_in;
      sb_neg_ff  <= sb_neg_in;
      zden_ff    <= zden_in;
      rnum_ff    <= rnum_in;
      rden_ff    <= rden_in;
      rzden_ff   <= rzden_in;
      rovf_ff    <= rovf_in;
   end

endmodule

// File: rtl/core/rfa_checker.sv
module rfa_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [rfa_pkg::DATA_BITS-1:0] result_num,
   input logic        [rfa_pkg::DEN_BITS-1:0]  result_den,
   input logic                                 zero_den,
   input logic                                 overflow
);

   // A stalled response item keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_num) && $stable(result_den)
         && $stable(zero_den) && $stable(overflow))
      else $error("stalled response item changed");

   // The block works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in progress");

   // An overflowing result is reported as 0/1.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && overflow |-> result_num == '0 && result_den == rfa_pkg::DEN_BITS'(1))
      else $error("overflow item is not 0/1");

   // The denominator is never zero, and a zero numerator reduces the denominator to one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> result_den != '0 && (result_num != '0 || result_den == rfa_pkg::DEN_BITS'(1)))
      else $error("bad reduced denominator");

endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .result_num (rsp_ch.result_num),
   .result_den (rsp_ch.result_den),
   .zero_den   (rsp_ch.zero_den),
   .overflow   (rsp_ch.overflow)
);
